@@ sv/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
package spq_pkg;

	// Default number of queue slots.
	localparam int unsigned DepthDefault = 16;

	// Field widths.
	localparam int unsigned PayW  = 8;
	localparam int unsigned PrioW = 8;
	localparam int unsigned FillW = 5;
	localparam int unsigned StatW = 2;

	// Stream payload widths.
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 48;

	// Operation codes carried in the input tuser.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Status codes carried in the output tuser.
	localparam logic [StatW-1:0] ST_DONE  = 2'd0;
	localparam logic [StatW-1:0] ST_FULL  = 2'd1;
	localparam logic [StatW-1:0] ST_EMPTY = 2'd2;

	// One stored entry: four payload words and a priority.
	typedef struct packed {
		logic [PrioW-1:0]       prio;
		logic [3:0][PayW-1:0]   pay;
	} entry_t;

	// Per-cycle command shared by every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

@@ sv/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    prev_entry,
	input  logic               prev_ahead,
	input  spq_pkg::entry_t    next_entry,
	output spq_pkg::entry_t    entry,
	output logic               ahead
);

	spq_pkg::entry_t entry_q;

	// The new entry belongs ahead of this slot when the slot is free or holds a
	// strictly larger priority; equal priorities stay in front.
	assign ahead = !occupied || (entry_q.prio > new_entry.prio);
	assign entry = entry_q;

	// Insert shifts toward the tail, remove shifts toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (prev_ahead) begin
				entry_q <= prev_entry;
			end else if (ahead) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ sv/stable_priority_queue_core.sv @@
// Stable sorted priority queue built as a chain of shifting slot cells.
//
// Input channel s_axis_*: one transfer is one operation. s_axis_tuser selects
// insert or remove; s_axis_tdata carries the entry to insert (ignored on a
// remove). Output channel m_axis_*: exactly one result transfer per operation,
// with the status in m_axis_tuser and the removed entry plus the fill level in
// m_axis_tdata. An insert into a full queue is dropped with status full; a
// remove from an empty queue reports status empty and changes nothing.
// Entries of equal priority leave in arrival order.
// The result is registered on the input transfer. One operation is taken
// every cycle unless the output stalls: every slot compares its priority
// with the new one in parallel and the chain shifts one slot that cycle.
// The result sits in an output register; while the receiver stalls, a new
// operation is taken only in a cycle where that register is being emptied.
// Reset empties the queue and clears the output valid at once; the slot
// contents are not cleared and are only read once written.
module stable_priority_queue_core #(
	parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// payload_0, payload_1, payload_2, payload_3, prio_in
	input  logic [spq_pkg::InDataW-1:0]   s_axis_tdata,
	// opcode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_payload_0, out_payload_1, out_payload_2, out_payload_3, prio_out,
	// fill, zero padding
	output logic [spq_pkg::OutDataW-1:0]  m_axis_tdata,
	// status
	output logic [spq_pkg::StatW-1:0]     m_axis_tuser
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic                        out_valid_q;
	logic [spq_pkg::StatW-1:0]   out_stat_q;
	spq_pkg::entry_t             out_entry_q;
	logic [spq_pkg::FillW-1:0]   out_fill_q;
	logic [CntW-1:0]             count_q;

	logic                        in_xfer;
	logic                        full;
	logic                        empty;
	logic [CntW-1:0]             count_next;
	logic [spq_pkg::StatW-1:0]   stat_next;
	spq_pkg::cell_ctrl_t         ctrl;
	spq_pkg::entry_t             new_entry;
	spq_pkg::entry_t             cell_entry [DEPTH];
	logic                        cell_ahead [DEPTH];

	// Take a new operation whenever the result register is free or draining.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);

	// Unpack the entry to insert, first field in the lowest bits.
	assign new_entry.pay[0] = s_axis_tdata[7:0];
	assign new_entry.pay[1] = s_axis_tdata[15:8];
	assign new_entry.pay[2] = s_axis_tdata[23:16];
	assign new_entry.pay[3] = s_axis_tdata[31:24];
	assign new_entry.prio   = s_axis_tdata[39:32];

	// Decide the chain command, the new count and the status.
	always_comb begin
		ctrl       = '0;
		count_next = count_q;
		stat_next  = spq_pkg::ST_DONE;
		if (s_axis_tuser == spq_pkg::OP_INSERT) begin
			if (full) begin
				stat_next = spq_pkg::ST_FULL;
			end else begin
				ctrl.ins   = in_xfer;
				count_next = count_q + CntW'(1);
			end
		end else begin
			if (empty) begin
				stat_next = spq_pkg::ST_EMPTY;
			end else begin
				ctrl.rem   = in_xfer;
				count_next = count_q - CntW'(1);
			end
		end
	end

	// Chain of slot cells, head at index zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t prev_e;
		spq_pkg::entry_t next_e;
		logic            prev_b;

		if (i == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_b = 1'b0;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_b = cell_ahead[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_e = cell_entry[i];
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (CntW'(i) < count_q),
			.new_entry   (new_entry),
			.prev_entry  (prev_e),
			.prev_ahead  (prev_b),
			.next_entry  (next_e),
			.entry       (cell_entry[i]),
			.ahead       (cell_ahead[i])
		);
	end

	// Control state: fill count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register, loaded on every input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_stat_q <= stat_next;
			out_fill_q <= spq_pkg::FillW'(count_next);
			if (ctrl.rem) begin
				out_entry_q <= cell_entry[0];
			end else begin
				out_entry_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tdata  = {3'b000, out_fill_q, out_entry_q.prio, out_entry_q.pay[3],
		out_entry_q.pay[2], out_entry_q.pay[1], out_entry_q.pay[0]};

endmodule
